// ===== rtl/shs_pkg.sv =====
// ============================================================================
// shs_pkg
// Shared types and constants for the stepper homing sequencer: register
// indexes, motor command codes, the phase encoding and the result record.
// ============================================================================
package shs_pkg;

    // Configuration port geometry.
    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth  = 24;

    // Register indexes on the configuration port.
    localparam logic [CfgIndexWidth-1:0] REG_STABLE_THRESHOLD = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_TRIGGERED_LEVEL  = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_FAST_SPEED_HZ    = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_SLOW_SPEED_HZ    = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_BACKOFF_STEPS    = 3'd4;

    // Register reset values.
    localparam logic [7:0]         STABLE_THRESHOLD_RST = 8'd10;
    localparam logic               TRIGGERED_LEVEL_RST  = 1'b0;
    localparam logic [23:0]        FAST_SPEED_HZ_RST    = 24'd1000;
    localparam logic [23:0]        SLOW_SPEED_HZ_RST    = 24'd100;
    localparam logic signed [23:0] BACKOFF_STEPS_RST    = 24'sd200;

    // Debounce counter saturation point.
    localparam logic [7:0] STABLE_COUNT_MAX = 8'd255;

    // Motor command codes.
    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_FAST    = 3'd1,
        CMD_BACKOFF = 3'd2,
        CMD_SLOW    = 3'd3,
        CMD_STOP    = 3'd4
    } motor_cmd_t;

    // Phase codes as they appear on the result item.
    localparam logic [1:0] PHASE_CODE_WAIT    = 2'd0;
    localparam logic [1:0] PHASE_CODE_FAST    = 2'd1;
    localparam logic [1:0] PHASE_CODE_BACKOFF = 2'd2;
    localparam logic [1:0] PHASE_CODE_SLOW    = 2'd3;

    // Sequencer state, one-hot.
    typedef enum logic [3:0] {
        PH_WAIT    = 4'b0001,
        PH_FAST    = 4'b0010,
        PH_BACKOFF = 4'b0100,
        PH_SLOW    = 4'b1000
    } phase_t;

    // One result item.
    typedef struct packed {
        logic [1:0]         phase;
        logic               press_event;
        logic signed [23:0] move_steps;
        logic [23:0]        speed_hz;
        motor_cmd_t         motor_command;
    } result_t;

    // Width of the packed result and of the output tdata bus.
    localparam int unsigned ResultWidth = $bits(result_t);
    localparam int unsigned MDataWidth  = ((ResultWidth + 7) / 8) * 8;

    // Map the one-hot phase to its two-bit code.
    function automatic logic [1:0] phase_code(input phase_t ph);
        logic [1:0] code;
        case (ph)
            PH_WAIT:    code = PHASE_CODE_WAIT;
            PH_FAST:    code = PHASE_CODE_FAST;
            PH_BACKOFF: code = PHASE_CODE_BACKOFF;
            PH_SLOW:    code = PHASE_CODE_SLOW;
            default:    code = PHASE_CODE_WAIT;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/stepper_homing_sequencer.sv =====
// ============================================================================
// stepper_homing_sequencer
// Debounced home switch plus homing sequencer, one result item per sample.
// ============================================================================
// Each input item is one sampling tick and yields exactly one result item.
// The block takes one item per clock while the result side keeps taking
// items: an item is held in the input register, where the debouncer and the
// phase machine evaluate it combinationally, and the result is held in the
// output register until it is taken. Write configuration only while no item
// is in flight.
module stepper_homing_sequencer (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Configuration write port.
    input  logic                                  cfg_wr_en,
    input  logic [shs_pkg::CfgIndexWidth-1:0]     cfg_index,
    input  logic [shs_pkg::CfgDataWidth-1:0]      cfg_wdata,
    // Sample input.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [7:0]                            s_axis_tdata,  // home_level, motor_running
    // Result output.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [shs_pkg::MDataWidth-1:0]        m_axis_tdata   // motor_command, speed_hz,
                                                                 // move_steps, press_event, phase
);
    import shs_pkg::*;

    // Configuration registers.
    logic [7:0]         stable_threshold_reg;
    logic               triggered_level_reg;
    logic [23:0]        fast_speed_hz_reg;
    logic [23:0]        slow_speed_hz_reg;
    logic signed [23:0] backoff_steps_reg;

    // Input stage.
    logic in_valid_reg;
    logic in_level_reg;
    logic in_running_reg;

    // Output stage.
    logic                  out_valid_reg;
    logic [MDataWidth-1:0] out_data_reg;

    logic    advance;
    logic    press;
    result_t result;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_threshold_reg <= STABLE_THRESHOLD_RST;
            triggered_level_reg  <= TRIGGERED_LEVEL_RST;
            fast_speed_hz_reg    <= FAST_SPEED_HZ_RST;
            slow_speed_hz_reg    <= SLOW_SPEED_HZ_RST;
            backoff_steps_reg    <= BACKOFF_STEPS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_STABLE_THRESHOLD: stable_threshold_reg <= cfg_wdata[7:0];
                REG_TRIGGERED_LEVEL:  triggered_level_reg  <= cfg_wdata[0];
                REG_FAST_SPEED_HZ:    fast_speed_hz_reg    <= cfg_wdata[23:0];
                REG_SLOW_SPEED_HZ:    slow_speed_hz_reg    <= cfg_wdata[23:0];
                REG_BACKOFF_STEPS:    backoff_steps_reg    <= $signed(cfg_wdata[23:0]);
                default: ;
            endcase
        end
    end

    // The held item moves on when the output register is free or being emptied.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_level_reg   <= s_axis_tdata[0];
            in_running_reg <= s_axis_tdata[1];
        end
    end

    shs_debounce u_debounce (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .advance          (advance),
        .level            (in_level_reg),
        .stable_threshold (stable_threshold_reg),
        .triggered_level  (triggered_level_reg),
        .press            (press)
    );

    shs_sequencer u_sequencer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .press         (press),
        .running       (in_running_reg),
        .fast_speed_hz (fast_speed_hz_reg),
        .slow_speed_hz (slow_speed_hz_reg),
        .backoff_steps (backoff_steps_reg),
        .result        (result)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {{(MDataWidth-ResultWidth){1'b0}}, result};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== rtl/shs_debounce.sv =====
// ============================================================================
// shs_debounce
// Counts consecutive stable samples of the home switch and raises at most one
// press per stable stretch at the triggered level, none for the stretch that follows reset.
// ============================================================================
module shs_debounce (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  logic       level,
    input  logic [7:0] stable_threshold,
    input  logic       triggered_level,
    output logic       press
);
    import shs_pkg::*;

    logic       last_level_reg,   last_level_next;
    logic       primed_reg,       primed_next;
    logic [7:0] stable_count_reg, stable_count_next;
    logic       reported_reg,     reported_next;

    logic ref_level;
    logic changed;
    logic reported_mid;

    // The first sample after reset primes the reference level.
    always_comb begin
        ref_level         = primed_reg ? last_level_reg : level;
        changed           = (level != ref_level);
        last_level_next   = level;
        primed_next       = 1'b1;
        if (changed) begin
            stable_count_next = '0;
            reported_mid      = 1'b0;
        end else begin
            reported_mid      = reported_reg;
            if (stable_count_reg != STABLE_COUNT_MAX) begin
                stable_count_next = stable_count_reg + 8'd1;
            end else begin
                stable_count_next = stable_count_reg;
            end
        end
        press = (stable_count_next > stable_threshold) && !reported_mid &&
                (level == triggered_level);
        reported_next = reported_mid | press;
    end

    // Debounce state moves only when the item leaves the input stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_level_reg   <= 1'b0;
            primed_reg       <= 1'b0;
            stable_count_reg <= '0;
            reported_reg     <= 1'b1;
        end else if (advance) begin
            last_level_reg   <= last_level_next;
            primed_reg       <= primed_next;
            stable_count_reg <= stable_count_next;
            reported_reg     <= reported_next;
        end
    end

endmodule

// ===== rtl/shs_sequencer.sv =====
// ============================================================================
// shs_sequencer
// Four-phase homing state machine: start press, fast reverse, back-off,
// slow reverse, zero and disable.
// ============================================================================
module shs_sequencer (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic                  press,
    input  logic                  running,
    input  logic [23:0]           fast_speed_hz,
    input  logic [23:0]           slow_speed_hz,
    input  logic signed [23:0]    backoff_steps,
    output shs_pkg::result_t      result
);
    import shs_pkg::*;

    phase_t phase_reg, phase_next;

    // Next phase and the command that goes with the transition.
    always_comb begin
        phase_next           = phase_reg;
        result.motor_command = CMD_NONE;
        result.speed_hz      = '0;
        result.move_steps    = '0;
        case (phase_reg)
            PH_WAIT: begin
                if (press) begin
                    result.motor_command = CMD_FAST;
                    result.speed_hz      = fast_speed_hz;
                    phase_next           = PH_FAST;
                end
            end
            PH_FAST: begin
                if (press) begin
                    result.motor_command = CMD_BACKOFF;
                    result.move_steps    = backoff_steps;
                    phase_next           = PH_BACKOFF;
                end
            end
            PH_BACKOFF: begin
                if (!running) begin
                    result.motor_command = CMD_SLOW;
                    result.speed_hz      = slow_speed_hz;
                    phase_next           = PH_SLOW;
                end
            end
            PH_SLOW: begin
                if (press) begin
                    result.motor_command = CMD_STOP;
                    phase_next           = PH_WAIT;
                end
            end
            default: begin
                phase_next = PH_WAIT;
            end
        endcase
        result.press_event = press;
        result.phase       = phase_code(phase_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_WAIT;
        end else if (advance) begin
            phase_reg <= phase_next;
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the stepper homing sequencer.
// ============================================================================
// An initial block builds a list of pending operations: switch samples,
// register writes and pauses. A clocked driver plays that list into the
// sample stream and the configuration port, and predicts the result item of
// every sample it hands over. A clocked monitor stalls the result stream at
// random and compares each result item, field by field, against the oldest
// prediction. Register writes and pauses wait until the block has gone idle.
// ============================================================================
module testbench;
    import shs_pkg::*;

    // Run shape.
    localparam int unsigned IdlePercent  = 26;
    localparam int unsigned SettleCycles = 4;
    localparam int unsigned TailCycles   = 8;
    localparam int unsigned CycleLimit   = 200000;
    localparam int unsigned RegCount     = 5;
    localparam int unsigned PrintLimit   = 40;

    typedef enum logic [1:0] {
        OP_SAMPLE,
        OP_WRITE,
        OP_PAUSE
    } op_kind_t;

    typedef struct packed {
        op_kind_t                 kind;
        logic                     calm;
        logic                     level;
        logic                     running;
        logic [CfgIndexWidth-1:0] index;
        logic [CfgDataWidth-1:0]  wdata;
    } pending_op_t;

    // Block ports; the inputs are known from time zero.
    logic                     aclk          = 1'b0;
    logic                     aresetn       = 1'b0;
    logic                     cfg_wr_en     = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_index     = '0;
    logic [CfgDataWidth-1:0]  cfg_wdata     = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [7:0]               s_axis_tdata  = '0;  // home_level, motor_running
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [MDataWidth-1:0]    m_axis_tdata;        // motor_command, speed_hz,
                                                   // move_steps, press_event, phase

    // Stimulus and scoreboard state.
    pending_op_t pending_ops[$];
    result_t     homing_expected[$];
    int unsigned items_queued   = 0;
    int unsigned items_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned cycle_count    = 0;
    int unsigned mismatch_count = 0;
    logic        gen_calm       = 1'b0;
    logic        calm_zone      = 1'b0;

    // Predicted register contents.
    logic [7:0]         cfg_threshold = STABLE_THRESHOLD_RST;
    logic               cfg_trigger   = TRIGGERED_LEVEL_RST;
    logic [23:0]        cfg_fast      = FAST_SPEED_HZ_RST;
    logic [23:0]        cfg_slow      = SLOW_SPEED_HZ_RST;
    logic signed [23:0] cfg_backoff   = BACKOFF_STEPS_RST;

    // Predicted debouncer and sequencer state.
    logic       sw_last     = 1'b0;
    logic       sw_primed   = 1'b0;
    logic [7:0] sw_count    = '0;
    logic       sw_reported = 1'b1;
    logic [1:0] seq_phase   = PHASE_CODE_WAIT;

    stepper_homing_sequencer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock and a single reset pulse.
    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Predicted register write.
    function automatic void homing_register_write(input logic [CfgIndexWidth-1:0] index,
                                                  input logic [CfgDataWidth-1:0] data);
        case (index)
            REG_STABLE_THRESHOLD: cfg_threshold = data[7:0];
            REG_TRIGGERED_LEVEL:  cfg_trigger   = data[0];
            REG_FAST_SPEED_HZ:    cfg_fast      = data;
            REG_SLOW_SPEED_HZ:    cfg_slow      = data;
            REG_BACKOFF_STEPS:    cfg_backoff   = data;
            default: ;
        endcase
    endfunction

    // Debounce one sample and advance the homing phase; returns the result item.
    function automatic result_t homing_predict(input logic level, input logic running);
        result_t r;
        logic    press;
        r     = '0;
        press = 1'b0;
        // The very first sample counts as stable.
        if (!sw_primed) begin
            sw_last   = level;
            sw_primed = 1'b1;
        end
        if (level != sw_last) begin
            sw_count    = '0;
            sw_reported = 1'b0;
        end else if (sw_count != STABLE_COUNT_MAX) begin
            sw_count = sw_count + 8'd1;
        end
        if (sw_count > cfg_threshold && !sw_reported && level == cfg_trigger) begin
            press       = 1'b1;
            sw_reported = 1'b1;
        end
        sw_last = level;

        // Presses are consumed in every phase but back-off, which waits for the motor to stop.
        r.motor_command = CMD_NONE;
        case (seq_phase)
            PHASE_CODE_WAIT: if (press) begin
                r.motor_command = CMD_FAST;
                r.speed_hz      = cfg_fast;
                seq_phase       = PHASE_CODE_FAST;
            end
            PHASE_CODE_FAST: if (press) begin
                r.motor_command = CMD_BACKOFF;
                r.move_steps    = cfg_backoff;
                seq_phase       = PHASE_CODE_BACKOFF;
            end
            PHASE_CODE_BACKOFF: if (!running) begin
                r.motor_command = CMD_SLOW;
                r.speed_hz      = cfg_slow;
                seq_phase       = PHASE_CODE_SLOW;
            end
            default: if (press) begin
                r.motor_command = CMD_STOP;
                seq_phase       = PHASE_CODE_WAIT;
            end
        endcase
        r.press_event = press;
        r.phase       = seq_phase;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        mismatch_count++;
        if (mismatch_count <= PrintLimit) begin
            $display("mismatch at result item %0d: %s got %h expected %h",
                     results_seen, what, got, want);
        end
    endtask

    // Driver: plays pending operations into the sample stream and config port.
    always @(posedge aclk) begin : drive_proc
        pending_op_t              op;
        logic                     next_valid;
        logic [7:0]               next_data;
        logic                     next_wr;
        logic [CfgIndexWidth-1:0] next_index;
        logic [CfgDataWidth-1:0]  next_wdata;
        int unsigned              sent_now;
        logic                     drained;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            cfg_wr_en     <= 1'b0;
        end else begin
            sent_now = items_sent;
            if (s_axis_tvalid && s_axis_tready) begin
                homing_expected.push_back(homing_predict(s_axis_tdata[0], s_axis_tdata[1]));
                sent_now = sent_now + 1;
            end
            // An item handed over at this edge is still in flight.
            drained    = (quiet_cycles >= SettleCycles) && !s_axis_tvalid;
            next_valid = s_axis_tvalid;
            next_data  = s_axis_tdata;
            next_wr    = 1'b0;
            next_index = cfg_index;
            next_wdata = cfg_wdata;

            // Hold a stalled item; otherwise take the next operation.
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                next_valid = 1'b0;
                if (pending_ops.size() != 0) begin
                    op = pending_ops[0];
                    case (op.kind)
                        OP_SAMPLE: if (op.calm || $urandom_range(99) >= IdlePercent) begin
                            next_valid = 1'b1;
                            next_data  = {6'd0, op.running, op.level};
                            calm_zone <= op.calm;
                            void'(pending_ops.pop_front());
                        end
                        OP_WRITE: if (drained) begin
                            next_wr    = 1'b1;
                            next_index = op.index;
                            next_wdata = op.wdata;
                            homing_register_write(op.index, op.wdata);
                            void'(pending_ops.pop_front());
                        end
                        default: if (drained) begin
                            void'(pending_ops.pop_front());
                        end
                    endcase
                end
            end

            quiet_cycles  <= (items_sent == results_seen && !s_axis_tvalid) ?
                             quiet_cycles + 1 : 0;
            items_sent    <= sent_now;
            s_axis_tvalid <= next_valid;
            s_axis_tdata  <= next_data;
            cfg_wr_en     <= next_wr;
            cfg_index     <= next_index;
            cfg_wdata     <= next_wdata;
        end
    end

    // Monitor: random back-pressure and field-by-field comparison.
    always @(posedge aclk) begin : check_proc
        result_t got;
        result_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = result_t'(m_axis_tdata[ResultWidth-1:0]);
                if (homing_expected.size() == 0) begin
                    report_mismatch("result item with nothing expected, phase",
                                    24'(got.phase), '0);
                end else begin
                    want = homing_expected.pop_front();
                    if (got.motor_command !== want.motor_command)
                        report_mismatch("motor_command", 24'(got.motor_command),
                                        24'(want.motor_command));
                    if (got.speed_hz !== want.speed_hz)
                        report_mismatch("speed_hz", got.speed_hz, want.speed_hz);
                    if (got.move_steps !== want.move_steps)
                        report_mismatch("move_steps", got.move_steps, want.move_steps);
                    if (got.press_event !== want.press_event)
                        report_mismatch("press_event", 24'(got.press_event),
                                        24'(want.press_event));
                    if (got.phase !== want.phase)
                        report_mismatch("phase", 24'(got.phase), 24'(want.phase));
                    results_seen <= results_seen + 1;
                end
            end
            m_axis_tready <= calm_zone || ($urandom_range(99) >= IdlePercent);
        end
    end

    // Stimulus builders.
    task automatic queue_sample(input logic level, input logic running);
        pending_op_t op;
        op         = '0;
        op.kind    = OP_SAMPLE;
        op.calm    = gen_calm;
        op.level   = level;
        op.running = running;
        pending_ops.push_back(op);
        items_queued++;
    endtask

    // A stretch of samples at one switch level; the motor mostly keeps running.
    task automatic queue_run(input logic level, input int unsigned len);
        repeat (len) queue_sample(level, $urandom_range(99) < 65);
    endtask

    task automatic queue_write(input logic [CfgIndexWidth-1:0] index,
                               input logic [CfgDataWidth-1:0] data);
        pending_op_t op;
        op       = '0;
        op.kind  = OP_WRITE;
        op.index = index;
        op.wdata = data;
        pending_ops.push_back(op);
    endtask

    task automatic queue_pause();
        pending_op_t op;
        op      = '0;
        op.kind = OP_PAUSE;
        pending_ops.push_back(op);
    endtask

    task automatic queue_setting(input logic [7:0] thr, input logic trig,
                                 input logic [23:0] fast, input logic [23:0] slow,
                                 input logic [23:0] backoff);
        queue_write(REG_STABLE_THRESHOLD, {16'd0, thr});
        queue_write(REG_TRIGGERED_LEVEL, {23'd0, trig});
        queue_write(REG_FAST_SPEED_HZ, fast);
        queue_write(REG_SLOW_SPEED_HZ, slow);
        queue_write(REG_BACKOFF_STEPS, backoff);
    endtask

    // Mostly clean presses, mixed with bounces, releases and noise.
    task automatic queue_episodes(input int unsigned count, input int unsigned thr,
                                  input logic trig);
        int unsigned stop_at;
        int unsigned roll;
        stop_at = items_queued + count;
        while (items_queued < stop_at) begin
            roll = $urandom_range(99);
            if (roll < 55) begin
                queue_run(!trig, $urandom_range(1, 4));
                queue_run(trig, thr + 2 + $urandom_range(0, 3));
            end else if (roll < 75) begin
                queue_run(trig, $urandom_range(1, thr + 1));
            end else if (roll < 88) begin
                queue_run(!trig, $urandom_range(1, 6));
            end else begin
                repeat ($urandom_range(1, 4))
                    queue_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // The switch polarity most recently queued for the random-settings phase.
    function automatic logic cfg_trigger_of_queue();
        logic trig;
        trig = TRIGGERED_LEVEL_RST;
        for (int i = pending_ops.size() - 1; i >= 0; i--) begin
            if (pending_ops[i].kind == OP_WRITE &&
                pending_ops[i].index == REG_TRIGGERED_LEVEL) begin
                trig = pending_ops[i].wdata[0];
                break;
            end
        end
        return trig;
    endfunction

    // Build the stimulus, then wait for the block to drain and decide.
    initial begin
        int unsigned thr;

        // Reset settings: the first sample primes the debouncer without a
        // press, then a bounce and a long stable low start the fast run.
        queue_sample(1'b0, 1'b0);
        queue_sample(1'b1, 1'b0);
        queue_run(1'b0, 12);

        // Threshold zero and extreme rates: back off on contact even though
        // the motor is still flagged idle on that tick, ignore a press while
        // backing off, leave on the first stopped tick, then stop and restart.
        queue_setting(8'd0, 1'b0, 24'h000000, 24'hFFFFFF, 24'h800000);
        queue_sample(1'b1, 1'b1);
        queue_sample(1'b0, 1'b1);
        queue_sample(1'b0, 1'b0);
        queue_sample(1'b1, 1'b1);
        queue_sample(1'b0, 1'b1);
        queue_sample(1'b0, 1'b1);
        queue_sample(1'b0, 1'b0);
        queue_sample(1'b1, 1'b0);
        queue_sample(1'b0, 1'b0);
        queue_sample(1'b0, 1'b0);
        queue_sample(1'b1, 1'b0);
        queue_sample(1'b0, 1'b0);
        queue_sample(1'b0, 1'b0);

        // Active-high switch, threshold zero, opposite extremes.
        queue_setting(8'd0, 1'b1, 24'hFFFFFF, 24'h000000, 24'h7FFFFF);
        queue_episodes(200, 0, 1'b1);

        // Small thresholds with neither side idling.
        thr = $urandom_range(1, 5);
        queue_setting(8'(thr), 1'b0, 24'($urandom), 24'($urandom), 24'($urandom));
        gen_calm = 1'b1;
        queue_episodes(220, thr, 1'b0);
        gen_calm = 1'b0;

        // Highest useful threshold: only a saturated count can press.
        queue_setting(8'd254, 1'b1, 24'($urandom), 24'($urandom), 24'($urandom));
        queue_run(1'b0, 3);
        queue_run(1'b1, 260);

        // Threshold at the counter ceiling: no press however long the level holds.
        queue_setting(8'd255, 1'b1, 24'($urandom), 24'($urandom), 24'($urandom));
        queue_run(1'b0, 2);
        queue_run(1'b1, 262);

        // Random settings; the unused indexes must not disturb anything, and
        // the sender holds off once until every result item is in.
        thr = $urandom_range(2, 8);
        queue_setting(8'(thr), 1'($urandom_range(0, 1)), 24'($urandom), 24'($urandom),
                      24'($urandom));
        for (int i = RegCount; i < (1 << CfgIndexWidth); i++)
            queue_write(CfgIndexWidth'(i), 24'($urandom));
        queue_episodes(125, thr, cfg_trigger_of_queue());
        queue_pause();
        queue_episodes(125, thr, cfg_trigger_of_queue());

        // Back to the power-up values.
        queue_setting(STABLE_THRESHOLD_RST, TRIGGERED_LEVEL_RST, FAST_SPEED_HZ_RST,
                      SLOW_SPEED_HZ_RST, BACKOFF_STEPS_RST);
        queue_episodes(200, 32'(STABLE_THRESHOLD_RST), TRIGGERED_LEVEL_RST);

        // Wait until everything is sent and answered, then a short tail.
        @(posedge aresetn);
        while (pending_ops.size() != 0 || s_axis_tvalid || items_sent != results_seen)
            @(negedge aclk);
        repeat (TailCycles) @(posedge aclk);
        if (homing_expected.size() != 0)
            report_mismatch("result items never delivered", 24'(homing_expected.size()),
                            '0);
        if (mismatch_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        while (cycle_count < CycleLimit) @(posedge aclk);
        $display("testbench failed");
        $finish;
    end

endmodule
